// ===== design/ptt_pkg.sv =====
// ptt_pkg: shared codes, entry layout and controller/datapath interface types
// for the periodic task timer table. No dependencies.
`default_nettype none

package ptt_pkg;

  // Command codes carried on the input channel.
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_ADD     = 3'd1;
  localparam logic [2:0] CMD_REMOVE  = 3'd2;
  localparam logic [2:0] CMD_ENABLE  = 3'd3;
  localparam logic [2:0] CMD_DISABLE = 3'd4;

  // Status codes carried on the output channel.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FIRED     = 3'd3;
  localparam logic [2:0] ST_IDLE      = 3'd4;

  // One table entry as held in the entry RAM.
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] period;
    logic [31:0] last;
  } ptt_entry_t;

  localparam int unsigned EntryW = $bits(ptt_entry_t);

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_ADD,
    OP_FIRE,
    OP_REMOVE,
    OP_SHIFT,
    OP_SET_EN
  } ptt_op_e;

  // Source of a pushed result: a plain status code or the held fired id.
  typedef enum logic {
    SRC_CODE,
    SRC_PEND
  } ptt_src_e;

  typedef struct packed {
    ptt_op_e    op;
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_next;
    logic       push;
    ptt_src_e   push_src;
    logic [2:0] push_status;
    logic       push_last;
  } ptt_ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       scan_end;
    logic       shift_end;
    logic       id_match;
    logic       due;
    logic       pend_v;
    logic       out_free;
  } ptt_sts_t;

endpackage

`default_nettype wire

// ===== design/ptt_ram.sv =====
// ptt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ptt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrW-1:0]     waddr_i,
  input  wire logic [Width-1:0]     wdata_i,
  input  wire logic [AddrW-1:0]     raddr_i,
  output logic      [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/ptt_dp.sv =====
// ptt_dp: datapath of the timer table: command registers, entry RAM, enable
// bits, live count, scan index and output register. Uses ptt_pkg, ptt_ram.
`default_nettype none

module ptt_dp #(
  parameter int unsigned MaxTasks = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ptt_pkg::ptt_ctrl_t ctrl_i,
  output ptt_pkg::ptt_sts_t      sts_o,
  input  wire logic [2:0]        command_i,
  input  wire logic [7:0]        task_id_i,
  input  wire logic [31:0]       period_ms_i,
  input  wire logic [31:0]       now_ms_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic      [2:0]        status_o,
  output logic      [7:0]        fired_id_o,
  output logic                   last_of_run_o
);

  import ptt_pkg::*;

  localparam int unsigned IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned CntW = $clog2(MaxTasks + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(MaxTasks);

  // Command payload, held for the whole run.
  logic [2:0]  cmd_q;
  logic [7:0]  id_q;
  logic [31:0] period_q;
  logic [31:0] now_q;

  logic [CntW-1:0]     live_q, live_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic [MaxTasks-1:0] en_q, en_d;
  logic                pend_v_q, pend_v_d;
  logic [7:0]          pend_id_q, pend_id_d;
  logic                out_valid_q, out_valid_d;
  logic [2:0]          out_status_q, out_status_d;
  logic [7:0]          out_id_q, out_id_d;
  logic                out_last_q, out_last_d;

  logic [IdxW-1:0]     idx_lo;
  logic [IdxW-1:0]     raddr;
  logic [IdxW-1:0]     waddr;
  logic                we;
  ptt_entry_t          wentry;
  ptt_entry_t          rentry;
  logic [EntryW-1:0]   rdata;
  logic [31:0]         due_time;
  logic [MaxTasks-1:0] en_shifted;
  logic                out_free;

  assign idx_lo = idx_q[IdxW-1:0];
  assign raddr  = ctrl_i.rd_next ? idx_lo + IdxW'(1) : idx_lo;
  assign rentry = ptt_entry_t'(rdata);

  always_comb begin
    we     = 1'b0;
    waddr  = idx_lo;
    wentry = rentry;
    case (ctrl_i.op)
      OP_ADD: begin
        we     = 1'b1;
        waddr  = live_q[IdxW-1:0];
        wentry = '{id: id_q, period: period_q, last: 32'd0};
      end
      OP_FIRE: begin
        we          = 1'b1;
        wentry.last = now_q;
      end
      OP_SHIFT: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  ptt_ram #(
    .Width(EntryW),
    .Depth(MaxTasks)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(EntryW'(wentry)),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_LOAD) begin
      cmd_q    <= command_i;
      id_q     <= task_id_i;
      period_q <= period_ms_i;
      now_q    <= now_ms_i;
    end
  end

  assign due_time   = rentry.last + rentry.period;
  assign en_shifted = en_q >> 1;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    live_d       = live_q;
    idx_d        = idx_q;
    en_d         = en_q;
    pend_v_d     = pend_v_q;
    pend_id_d    = pend_id_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_last_d   = out_last_q;

    if (ctrl_i.idx_clr) begin
      idx_d = '0;
    end else if (ctrl_i.idx_inc) begin
      idx_d = idx_q + CntW'(1);
    end

    // Drain the output register on a transfer; a push below overrides.
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl_i.push) begin
      out_valid_d = 1'b1;
      out_last_d  = ctrl_i.push_last;
      if (ctrl_i.push_src == SRC_PEND) begin
        out_status_d = ST_FIRED;
        out_id_d     = pend_id_q;
        pend_v_d     = 1'b0;
      end else begin
        out_status_d = ctrl_i.push_status;
        out_id_d     = 8'd0;
      end
    end

    case (ctrl_i.op)
      OP_LOAD: begin
        pend_v_d = 1'b0;
      end
      OP_ADD: begin
        en_d[live_q[IdxW-1:0]] = 1'b0;
        live_d                 = live_q + CntW'(1);
      end
      OP_FIRE: begin
        pend_v_d  = 1'b1;
        pend_id_d = rentry.id;
      end
      OP_REMOVE: begin
        // Close the gap in the enable bits at the hit slot.
        for (int k = 0; k < MaxTasks; k++) begin
          if (CntW'(k) >= idx_q) begin
            en_d[k] = en_shifted[k];
          end
        end
        live_d = live_q - CntW'(1);
      end
      OP_SET_EN: begin
        en_d[idx_lo] = (cmd_q == CMD_ENABLE);
      end
      default: begin
        live_d = live_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      idx_q       <= '0;
      en_q        <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      live_q      <= live_d;
      idx_q       <= idx_d;
      en_q        <= en_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q    <= pend_id_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_last_q   <= out_last_d;
  end

  assign sts_o.cmd       = cmd_q;
  assign sts_o.full      = (live_q == FullCnt);
  assign sts_o.scan_end  = (idx_q == live_q);
  assign sts_o.shift_end = (idx_q >= live_q);
  assign sts_o.id_match  = (rentry.id == id_q);
  assign sts_o.due       = en_q[idx_lo] && (due_time <= now_q);
  assign sts_o.pend_v    = pend_v_q;
  assign sts_o.out_free  = out_free;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign fired_id_o    = out_id_q;
  assign last_of_run_o = out_last_q;

endmodule

`default_nettype wire

// ===== design/ptt_ctrl.sv =====
// ptt_ctrl: state machine that sequences scans, shifts and replies of the
// timer table. Uses ptt_pkg; drives ptt_dp through ptt_ctrl_t.
`default_nettype none

module ptt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ptt_pkg::ptt_sts_t sts_i,
  output ptt_pkg::ptt_ctrl_t     ctrl_o
);

  import ptt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_ADD,
    S_DONE_OK,
    S_DONE_SCAN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d            = state_q;
    ctrl_o             = '0;
    ctrl_o.op          = OP_NONE;
    ctrl_o.push_src    = SRC_CODE;
    ctrl_o.push_status = ST_OK;
    in_ready_o         = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.op      = OP_LOAD;
          ctrl_o.idx_clr = 1'b1;
          state_d        = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        // Dispatch on the loaded command; the scan reads slot idx.
        case (sts_i.cmd)
          CMD_ADD: begin
            state_d = S_ADD;
          end
          CMD_TICK, CMD_REMOVE, CMD_ENABLE, CMD_DISABLE: begin
            state_d = sts_i.scan_end ? S_DONE_SCAN : S_SCAN_EV;
          end
          default: begin
            state_d = S_DONE_OK;
          end
        endcase
      end
      S_SCAN_EV: begin
        if (sts_i.cmd == CMD_TICK) begin
          if (!sts_i.due) begin
            ctrl_o.idx_inc = 1'b1;
            state_d        = S_SCAN_RD;
          end else if (!sts_i.pend_v || sts_i.out_free) begin
            // Release the previous fired entry, hold this one.
            ctrl_o.op       = OP_FIRE;
            ctrl_o.push     = sts_i.pend_v;
            ctrl_o.push_src = SRC_PEND;
            ctrl_o.idx_inc  = 1'b1;
            state_d         = S_SCAN_RD;
          end
        end else if (sts_i.id_match) begin
          if (sts_i.cmd == CMD_REMOVE) begin
            ctrl_o.op = OP_REMOVE;
            state_d   = S_SHIFT_RD;
          end else begin
            ctrl_o.op = OP_SET_EN;
            state_d   = S_DONE_OK;
          end
        end else begin
          ctrl_o.idx_inc = 1'b1;
          state_d        = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts_i.shift_end) begin
          state_d = S_DONE_OK;
        end else begin
          ctrl_o.rd_next = 1'b1;
          state_d        = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ctrl_o.op      = OP_SHIFT;
        ctrl_o.idx_inc = 1'b1;
        state_d        = S_SHIFT_RD;
      end
      S_ADD: begin
        if (sts_i.out_free) begin
          ctrl_o.push      = 1'b1;
          ctrl_o.push_last = 1'b1;
          if (sts_i.full) begin
            ctrl_o.push_status = ST_FULL;
          end else begin
            ctrl_o.op          = OP_ADD;
            ctrl_o.push_status = ST_OK;
          end
          state_d = S_IDLE;
        end
      end
      S_DONE_OK: begin
        if (sts_i.out_free) begin
          ctrl_o.push        = 1'b1;
          ctrl_o.push_last   = 1'b1;
          ctrl_o.push_status = ST_OK;
          state_d            = S_IDLE;
        end
      end
      S_DONE_SCAN: begin
        if (sts_i.out_free) begin
          ctrl_o.push      = 1'b1;
          ctrl_o.push_last = 1'b1;
          if (sts_i.cmd != CMD_TICK) begin
            ctrl_o.push_status = ST_NOT_FOUND;
          end else if (sts_i.pend_v) begin
            ctrl_o.push_src = SRC_PEND;
          end else begin
            ctrl_o.push_status = ST_IDLE;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/periodic_task_timer_table.sv =====
// periodic_task_timer_table: top level of the periodic task timer table.
// Depends on ptt_pkg, ptt_ctrl, ptt_dp (which holds ptt_ram).
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one command per transfer:
//   tick with now_ms_i, add with task_id_i and period_ms_i, remove, enable or
//   disable with task_id_i. Output channel (out_valid_o / out_ready_i) carries
//   result items; last_of_run_o marks the final one of each command.
//   A tick gives one "fired" result per due enabled task in table order, or a
//   single "nothing due" result; every other command gives one result.
//   One command is processed at a time; in_ready_o is high only between runs.
//   A tick reads each live entry in table order: a RAM read, then a compare.
//   Remove scans to the hit, then moves each later entry down one slot (a
//   RAM read, then a write); add does no scan; enable and disable stop at
//   the hit. A miss scans every live entry. The entry RAM has a single
//   read port with registered data.
//   Results pass through one output register: a stalled receiver holds the
//   scan at the next fired entry, and the next command is taken while the
//   final result still waits. Reset empties the table and drops any result;
//   no clearing pass is needed since only live slots are ever read.
`default_nettype none

module periodic_task_timer_table #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [7:0]  task_id_i,
  input  wire logic [31:0] period_ms_i,
  input  wire logic [31:0] now_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [2:0]  status_o,
  output logic      [7:0]  fired_id_o,
  output logic             last_of_run_o
);

  import ptt_pkg::*;

  ptt_ctrl_t ctrl;
  ptt_sts_t  sts;

  // Sequence the run: scan, shift, reply.
  ptt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .ctrl_o    (ctrl)
  );

  // Hold entries, enable bits and the output register.
  ptt_dp #(
    .MaxTasks(MAX_TASKS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .sts_o        (sts),
    .command_i    (command_i),
    .task_id_i    (task_id_i),
    .period_ms_i  (period_ms_i),
    .now_ms_i     (now_ms_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .fired_id_o   (fired_id_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

`default_nettype wire

// ===== design/ptt_checker.sv =====
// ptt_checker: port-level assertions for periodic_task_timer_table, bound to
// the top level below. Uses ptt_pkg.
`default_nettype none

module ptt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [2:0]  command_i,
  input wire logic [7:0]  task_id_i,
  input wire logic [31:0] period_ms_i,
  input wire logic [31:0] now_ms_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  status_o,
  input wire logic [7:0]  fired_id_o,
  input wire logic        last_of_run_o
);

  import ptt_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(fired_id_o) && $stable(last_of_run_o))
    else $error("output changed while stalled");

  // Only a fired result carries an id.
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_FIRED) |-> fired_id_o == 8'd0)
    else $error("nonzero id on a result that did not fire");

  // Every result other than a fired task closes its run.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_FIRED) |-> last_of_run_o)
    else $error("single result not marked last");

  // A command transfer starts a run; no second command right behind it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after a command transfer");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (.*);

`default_nettype wire

// ===== dv/periodic_task_timer_table_test.sv =====
// periodic_task_timer_table_test: self-checking bench for the periodic task timer
// table; directed edge cases, a long output stall, then random command traffic.
// Depends on ptt_pkg and periodic_task_timer_table.
`timescale 1ns / 100ps

module periodic_task_timer_table_test;
  import ptt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  // Command codes the block does not define; it answers them with a plain ok.
  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;
  // Longest command: a scan or remove over a full table.
  localparam int DRAIN_CYCLES = 4 * TABLE_DEPTH + 40;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 120;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] fired_id;
    logic       last_of_run;
  } timer_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i = CMD_TICK;
  logic [7:0]  task_id_i = 8'd0;
  logic [31:0] period_ms_i = 32'd0;
  logic [31:0] now_ms_i = 32'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  fired_id_o;
  logic        last_of_run_o;

  // Shadow copy of the task table, kept in step with every accepted transfer.
  logic [7:0]  tbl_id     [TABLE_DEPTH];
  logic [31:0] tbl_period [TABLE_DEPTH];
  logic [31:0] tbl_last   [TABLE_DEPTH];
  logic        tbl_en     [TABLE_DEPTH];
  int          tbl_count = 0;

  // Results the block still owes, oldest first.
  timer_result_t awaited_results[$];

  int          mismatches = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  logic [31:0] clock_ms = 32'd0;

  periodic_task_timer_table #(
    .MAX_TASKS(TABLE_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .task_id_i    (task_id_i),
    .period_ms_i  (period_ms_i),
    .now_ms_i     (now_ms_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .fired_id_o   (fired_id_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one accepted command to the shadow table and queue the results it owes.
  task automatic table_apply(input logic [2:0] cmd, input logic [7:0] id,
                             input logic [31:0] period, input logic [31:0] now);
    int          hit;
    logic [31:0] due_at;
    logic [7:0]  fired[$];
    hit = -1;
    // Lookups only ever search live slots, first match wins.
    for (int i = 0; i < tbl_count; i++) begin
      if (hit < 0 && tbl_id[i] == id) hit = i;
    end
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < tbl_count; i++) begin
          due_at = tbl_last[i] + tbl_period[i];  // wraps at 32 bits
          if (tbl_en[i] && due_at <= now) begin
            tbl_last[i] = now;
            fired.push_back(tbl_id[i]);
          end
        end
        if (fired.size() == 0) begin
          awaited_results.push_back('{ST_IDLE, 8'd0, 1'b1});
        end
        for (int j = 0; j < fired.size(); j++) begin
          awaited_results.push_back('{ST_FIRED, fired[j], j == fired.size() - 1});
        end
      end
      CMD_ADD: begin
        if (tbl_count >= TABLE_DEPTH) begin
          awaited_results.push_back('{ST_FULL, 8'd0, 1'b1});
        end else begin
          tbl_id[tbl_count] = id;
          tbl_period[tbl_count] = period;
          tbl_last[tbl_count] = 32'd0;
          tbl_en[tbl_count] = 1'b0;
          tbl_count++;
          awaited_results.push_back('{ST_OK, 8'd0, 1'b1});
        end
      end
      CMD_REMOVE: begin
        if (hit < 0) begin
          awaited_results.push_back('{ST_NOT_FOUND, 8'd0, 1'b1});
        end else begin
          // Close the gap: later live entries move down one slot.
          for (int i = hit; i + 1 < tbl_count; i++) begin
            tbl_id[i] = tbl_id[i + 1];
            tbl_period[i] = tbl_period[i + 1];
            tbl_last[i] = tbl_last[i + 1];
            tbl_en[i] = tbl_en[i + 1];
          end
          tbl_count--;
          tbl_en[tbl_count] = 1'b0;
          awaited_results.push_back('{ST_OK, 8'd0, 1'b1});
        end
      end
      CMD_ENABLE, CMD_DISABLE: begin
        if (hit < 0) begin
          awaited_results.push_back('{ST_NOT_FOUND, 8'd0, 1'b1});
        end else begin
          tbl_en[hit] = (cmd == CMD_ENABLE);
          awaited_results.push_back('{ST_OK, 8'd0, 1'b1});
        end
      end
      default: awaited_results.push_back('{ST_OK, 8'd0, 1'b1});
    endcase
  endtask

  // Offer one command and hold it until the transfer happens. Called at a
  // rising edge; valid stays high across back-to-back commands so it never
  // takes two assignments in one step.
  task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] id,
                          input logic [31:0] period, input logic [31:0] now);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < tx_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    task_id_i <= id;
    period_ms_i <= period;
    now_ms_i <= now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    table_apply(cmd, id, period, now);
  endtask

  // Drop valid, then wait for every owed result plus a settle window.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Empty-table lookups, reserved codes, field extremes, wrapping due times,
  // first-match lookups with a duplicate id, and removal from the middle.
  task automatic test_directed_edges();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_cmd(CMD_TICK, 8'h00, 32'h0, 32'h0);              // empty: nothing due
    send_cmd(CMD_REMOVE, 8'hFF, 32'h0, 32'h0);            // empty: not found
    send_cmd(CMD_ENABLE, 8'h00, 32'h0, 32'h0);
    send_cmd(CMD_DISABLE, 8'h00, 32'h0, 32'h0);
    send_cmd(CMD_RSVD_LO, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_RSVD_HI, 8'h00, 32'h0, 32'h0);
    send_cmd(CMD_ADD, 8'h00, 32'h0, 32'h0);               // zero period
    send_cmd(CMD_ADD, 8'hFF, 32'hFFFF_FFFF, 32'h0);       // largest period
    send_cmd(CMD_ADD, 8'h00, 32'd5, 32'h0);               // duplicate id
    send_cmd(CMD_ADD, 8'h5A, 32'd2, 32'h0);
    send_cmd(CMD_TICK, 8'h00, 32'h0, 32'h0);              // all disabled
    send_cmd(CMD_ENABLE, 8'h00, 32'h0, 32'h0);            // hits first id 0 only
    send_cmd(CMD_ENABLE, 8'hFF, 32'h0, 32'h0);
    send_cmd(CMD_ENABLE, 8'h5A, 32'h0, 32'h0);
    send_cmd(CMD_TICK, 8'h00, 32'h0, 32'h0);              // zero period due at once
    send_cmd(CMD_TICK, 8'h00, 32'h0, 32'hFFFF_FFFF);      // three fire in order
    send_cmd(CMD_TICK, 8'h00, 32'h0, 32'h0);              // sums wrap, none due
    send_cmd(CMD_TICK, 8'h00, 32'h0, 32'h1);              // wrapped sum now due
    send_cmd(CMD_DISABLE, 8'h00, 32'h0, 32'h0);
    send_cmd(CMD_REMOVE, 8'hFF, 32'h0, 32'h0);            // middle entry, shift down
    send_cmd(CMD_ENABLE, 8'h00, 32'h0, 32'h0);
    send_cmd(CMD_REMOVE, 8'h00, 32'h0, 32'h0);            // duplicate moves to front
    send_cmd(CMD_REMOVE, 8'h77, 32'h0, 32'h0);            // not found
    send_cmd(CMD_TICK, 8'h00, 32'h0, 32'hFFFF_FFFF);
    wait_idle();
  endtask

  // Stall the receiver for a long stretch while commands keep coming, so the
  // output register fills and the block stops taking input.
  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    for (int k = 0; k < 6; k++) begin
      send_cmd(CMD_ADD, 8'(8'h10 + k), 32'(k), $urandom);
      send_cmd(CMD_ENABLE, 8'(8'h10 + k), $urandom, $urandom);
    end
    for (int k = 1; k <= 3; k++) send_cmd(CMD_TICK, 8'($urandom), $urandom, 32'(100 * k));
    wait_idle();
  endtask

  // One random command. Ids mostly name live tasks so lookups hit; the clock
  // mostly creeps forward so ticks fire, with the odd jump anywhere.
  task automatic send_random(input int add_pct, input int rm_pct);
    int          pick;
    logic [2:0]  cmd;
    logic [7:0]  id;
    logic [31:0] period;
    logic [31:0] now;
    pick = $urandom_range(0, 99);
    if (pick < 3) cmd = CMD_RSVD_LO + 3'($urandom_range(0, CMD_RSVD_HI - CMD_RSVD_LO));
    else if (pick < 3 + add_pct) cmd = CMD_ADD;
    else if (pick < 3 + add_pct + rm_pct) cmd = CMD_REMOVE;
    else if (pick < 18 + add_pct + rm_pct) cmd = CMD_ENABLE;
    else if (pick < 26 + add_pct + rm_pct) cmd = CMD_DISABLE;
    else cmd = CMD_TICK;
    if (tbl_count > 0 && $urandom_range(0, 3) != 0) begin
      id = tbl_id[$urandom_range(0, tbl_count - 1)];
    end else begin
      id = 8'($urandom_range(0, 255));
    end
    period = ($urandom_range(0, 3) != 0) ? 32'($urandom_range(0, 40)) : $urandom;
    now = $urandom;
    if (cmd == CMD_TICK) begin
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + 32'($urandom_range(0, 25));
      now = clock_ms;
    end
    send_cmd(cmd, id, period, now);
  endtask

  // Alternate growing and shrinking stretches so the table swings between
  // empty and full under the given idle rates.
  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if ((k / 60) % 2 == 0) send_random(35, 5);
      else send_random(5, 35);
    end
    wait_idle();
  endtask

  // Receiver: random ready, or a long hold when asked, counted here.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Compare every result transfer against the oldest owed result.
  always @(posedge clk_i) begin : result_check
    timer_result_t owed;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d fired_id %0d last_of_run %0d",
               status_o, fired_id_o, last_of_run_o);
        mismatches++;
      end else begin
        owed = awaited_results.pop_front();
        if (status_o !== owed.status) begin
          $error("status: expected %0d, got %0d", owed.status, status_o);
          mismatches++;
        end
        if (fired_id_o !== owed.fired_id) begin
          $error("fired_id: expected %0d, got %0d", owed.fired_id, fired_id_o);
          mismatches++;
        end
        if (last_of_run_o !== owed.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", owed.last_of_run, last_of_run_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_output_stall();
    test_random_traffic(21, 48);
    test_random_traffic(48, 21);
    test_random_traffic(0, 0);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
